### hdl/avclps_pkg.sv
// Shared types and constants for the AVC length-prefix to start-code unit.
`timescale 1ns / 1ps

package avclps_pkg;

   // Input word: one byte of the length-prefixed access unit.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       unit_last;
      logic       container_sync;
   } req_word_type;

   // Output word: passed-on byte plus per-unit flags on the last byte.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       is_discardable;
      logic       is_sync_frame;
      logic       format_error;
   } rsp_word_type;

   // Where in a NAL the next byte falls.
   typedef enum logic [2:0] {
      ST_LENGTH  = 3'b001,
      ST_HEADER  = 3'b010,
      ST_PAYLOAD = 3'b100
   } phase_type;

   localparam logic [4:0] NAL_TYPE_MASK   = 5'h1f;
   localparam logic [4:0] NAL_TYPE_IDR    = 5'd5;
   localparam int         FORBIDDEN_BIT   = 7;
   localparam logic [7:0] START_CODE_LAST = 8'h01;
   localparam logic [7:0] START_CODE_ZERO = 8'h00;

endpackage

### hdl/avc_length_prefix_to_startcode_unit.sv
// AVC length-prefix to start-code converter: one byte in, one byte out.
// Each accepted req word passes the input register, then the result register,
// and waits there while rsp_stall holds the result. Throughput: one byte per
// cycle unless rsp_stall holds the result; the NAL byte counter decrement and
// the prefix shift both finish in the single process stage.
// Reset (synchronous, active high) empties both stages, sets mode to replace,
// and returns to length byte zero at the start of a unit.
`timescale 1ns / 1ps

module avc_length_prefix_to_startcode_unit
   import avclps_pkg::*;
#(
   parameter int LENGTH_BYTES = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_write_enable,
   input  logic         csr_write_data
);

   localparam int CNT_W = 8 * LENGTH_BYTES;
   localparam int IDX_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LENGTH_BYTES - 1);

   // Pipeline registers
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         out_valid_ff;
   rsp_word_type out_word_ff;
   rsp_word_type out_word_in;

   // Parse state
   logic             mode_ff;
   phase_type        phase_ff,    phase_in;
   logic [IDX_W-1:0] idx_ff,      idx_in;
   logic [CNT_W-1:0] cnt_ff,      cnt_in;
   logic             discard_ff,  discard_in;
   logic             sync_ff,     sync_in;
   logic             error_ff,    error_in;
   logic             at_start_ff, at_start_in;

   logic in_move;
   logic out_load;
   logic in_load;

   // Result register frees when empty or when its word leaves.
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && out_load;
   assign in_load   = !in_valid_ff || out_load;
   assign req_stall = !in_load;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   always_comb begin
      logic [7:0] b;
      logic       disc, sync, err;
      b           = in_word_ff.data_byte;
      disc        = at_start_ff ? 1'b1 : discard_ff;
      sync        = at_start_ff ? in_word_ff.container_sync : sync_ff;
      err         = at_start_ff ? 1'b0 : error_ff;
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      out_word_in = '0;
      out_word_in.out_byte = b;
      out_word_in.out_last = in_word_ff.unit_last;

      unique case (phase_ff)
         ST_HEADER: begin
            if (b[FORBIDDEN_BIT]) err = 1'b1;
            if (b[6:5] != 2'b00) disc = 1'b0;
            if ((b[4:0] & NAL_TYPE_MASK) == NAL_TYPE_IDR) sync = 1'b1;
            cnt_in   = cnt_ff - CNT_W'(1);
            phase_in = (cnt_in == '0) ? ST_LENGTH : ST_PAYLOAD;
            idx_in   = '0;
         end
         ST_PAYLOAD: begin
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_in == '0) begin
               phase_in = ST_LENGTH;
               idx_in   = '0;
            end
         end
         default: begin
            cnt_in = (idx_ff == '0) ? CNT_W'(b) : ((cnt_ff << 8) | CNT_W'(b));
            if (mode_ff)
               out_word_in.out_byte = (idx_ff == IDX_LAST) ? START_CODE_LAST
                                                           : START_CODE_ZERO;
            if (idx_ff == IDX_LAST) begin
               phase_in = (cnt_in == '0) ? ST_LENGTH : ST_HEADER;
               idx_in   = '0;
            end else begin
               phase_in = ST_LENGTH;
               idx_in   = idx_ff + IDX_W'(1);
            end
         end
      endcase

      at_start_in = 1'b0;
      if (in_word_ff.unit_last) begin
         // unit ended inside a prefix or a NAL
         if (!(phase_in == ST_LENGTH && idx_in == '0)) err = 1'b1;
         out_word_in.is_discardable = disc;
         out_word_in.is_sync_frame  = sync;
         out_word_in.format_error   = err;
         phase_in    = ST_LENGTH;
         idx_in      = '0;
         cnt_in      = '0;
         at_start_in = 1'b1;
      end
      discard_in = disc;
      sync_in    = sync;
      error_in   = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= 1'b1;
         phase_ff     <= ST_LENGTH;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         discard_ff   <= 1'b1;
         sync_ff      <= 1'b0;
         error_ff     <= 1'b0;
         at_start_ff  <= 1'b1;
      end else begin
         if (csr_write_enable) mode_ff <= csr_write_data;
         if (in_load) in_valid_ff <= req_valid;
         if (out_load) out_valid_ff <= in_valid_ff;
         if (in_move) begin
            phase_ff    <= phase_in;
            idx_ff      <= idx_in;
            cnt_ff      <= cnt_in;
            discard_ff  <= discard_in;
            sync_ff     <= sync_in;
            error_ff    <= error_in;
            at_start_ff <= at_start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) in_word_ff <= req_word;
      if (in_move) out_word_ff <= out_word_in;
   end

`ifndef NO_ASSERTIONS
   a_flags_only_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.out_last |->
         !(rsp_word.is_discardable || rsp_word.is_sync_frame || rsp_word.format_error))
      else $error("unit flags set on a word that is not the last");

   a_last_restarts_unit: assert property (@(posedge clock) disable iff (reset)
      in_move && in_word_ff.unit_last |=>
         at_start_ff && phase_ff == ST_LENGTH && idx_ff == '0 && cnt_ff == '0)
      else $error("parser did not return to unit start after last byte");

   a_open_nal_has_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == ST_HEADER || phase_ff == ST_PAYLOAD |-> cnt_ff != '0)
      else $error("inside a NAL with a zero byte count");

   a_result_follows_input: assert property (@(posedge clock) disable iff (reset)
      in_move |=> rsp_valid)
      else $error("processed word did not reach the result register");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the AVC length-prefix to start-code unit.
`timescale 1ns / 1ps

module tb_top;
   import avclps_pkg::*;

   localparam int LEN_BYTES     = 4;
   localparam int STALL_LIMIT   = 500;
   localparam int WORDS_PER_RUN = 80;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_write_enable = 1'b0;
   logic         csr_write_data = 1'b0;

   avc_length_prefix_to_startcode_unit #(
      .LENGTH_BYTES(LEN_BYTES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type out;
   } stim_row_type;

   // predictor state
   phase_type   nal_phase;
   int          len_idx;
   logic [31:0] nal_left;
   bit          drop_acc, sync_acc, err_acc, unit_fresh, swap_mode;

   rsp_word_type out_word_q[$];
   req_word_type unit_q[$];
   stim_row_type stim_table[$];

   bit idle_on = 1'b1;
   int stall_left = 0;
   int fail_count = 0;
   int words_in = 0;
   int units_seen = 0;
   int err_units = 0;
   int quiet_cycles = 0;

   function automatic rsp_word_type convert_byte(input req_word_type w);
      rsp_word_type r;
      r = '0;
      r.out_byte = w.data_byte;
      r.out_last = w.unit_last;
      if (unit_fresh) begin
         drop_acc   = 1'b1;
         sync_acc   = w.container_sync;
         err_acc    = 1'b0;
         unit_fresh = 1'b0;
      end
      case (nal_phase)
         ST_HEADER: begin
            if (w.data_byte[FORBIDDEN_BIT]) err_acc = 1'b1;
            if (w.data_byte[6:5] != 2'b00) drop_acc = 1'b0;
            if ((w.data_byte[4:0] & NAL_TYPE_MASK) == NAL_TYPE_IDR) sync_acc = 1'b1;
            nal_left  = nal_left - 1;
            nal_phase = (nal_left == 0) ? ST_LENGTH : ST_PAYLOAD;
            len_idx   = 0;
         end
         ST_PAYLOAD: begin
            nal_left = nal_left - 1;
            if (nal_left == 0) begin
               nal_phase = ST_LENGTH;
               len_idx   = 0;
            end
         end
         default: begin
            nal_left = (len_idx == 0) ? {24'h0, w.data_byte} : {nal_left[23:0], w.data_byte};
            if (swap_mode)
               r.out_byte = (len_idx == LEN_BYTES - 1) ? START_CODE_LAST : START_CODE_ZERO;
            if (len_idx == LEN_BYTES - 1) begin
               len_idx   = 0;
               // zero-length NAL: next byte is a new prefix
               nal_phase = (nal_left == 0) ? ST_LENGTH : ST_HEADER;
            end else begin
               len_idx = len_idx + 1;
            end
         end
      endcase
      if (w.unit_last) begin
         if (!(nal_phase == ST_LENGTH && len_idx == 0)) err_acc = 1'b1;
         r.is_discardable = drop_acc;
         r.is_sync_frame  = sync_acc;
         r.format_error   = err_acc;
         nal_phase  = ST_LENGTH;
         len_idx    = 0;
         nal_left   = '0;
         unit_fresh = 1'b1;
      end
      return r;
   endfunction

   function automatic stim_row_type mk_row(input logic [7:0] b, input bit last, input bit cs,
                                           input bit typed, input rsp_word_type out);
      stim_row_type s;
      s.word.data_byte      = b;
      s.word.unit_last      = last;
      s.word.container_sync = cs;
      s.typed = typed;
      s.out   = out;
      return s;
   endfunction

   task automatic send_word(input req_word_type w, input bit typed, input rsp_word_type out);
      rsp_word_type guess;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      guess = convert_byte(w);
      out_word_q.push_back(typed ? out : guess);
      words_in++;
   endtask

   // only while idle: drain every pending word first
   task automatic set_mode(input bit m);
      req_valid <= 1'b0;
      while (out_word_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      swap_mode = m;
   endtask

   task automatic gen_unit();
      int           kind, sel, len, cut;
      logic [31:0]  len_word;
      req_word_type w;
      unit_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 13) begin
         // noise
         repeat ($urandom_range(1, 8)) begin
            w.data_byte      = 8'($urandom_range(0, 255));
            w.unit_last      = 1'b0;
            w.container_sync = 1'($urandom_range(0, 1));
            unit_q.push_back(w);
         end
      end else begin
         repeat ($urandom_range(1, 3)) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) len = 0;
            else if (sel == 1) len = $urandom_range(250, 300);
            else len = $urandom_range(1, 10);
            len_word = len;
            w.unit_last = 1'b0;
            for (int i = LEN_BYTES - 1; i >= 0; i--) begin
               w.data_byte      = len_word[8*i +: 8];
               w.container_sync = 1'($urandom_range(0, 1));
               unit_q.push_back(w);
            end
            if (len > 0) begin
               w.data_byte[7]   = ($urandom_range(0, 7) == 0);
               w.data_byte[6:5] = $urandom_range(0, 1) ? 2'b00 : 2'($urandom_range(1, 3));
               w.data_byte[4:0] = ($urandom_range(0, 9) < 3) ? NAL_TYPE_IDR
                                                             : 5'($urandom_range(0, 31));
               w.container_sync = 1'($urandom_range(0, 1));
               unit_q.push_back(w);
               repeat (len - 1) begin
                  w.data_byte      = 8'($urandom_range(0, 255));
                  w.container_sync = 1'($urandom_range(0, 1));
                  unit_q.push_back(w);
               end
            end
         end
         if (kind < 25) begin
            cut = $urandom_range(1, unit_q.size());
            while (unit_q.size() > cut) void'(unit_q.pop_back());
         end
      end
      unit_q[0].container_sync = 1'($urandom_range(0, 1));
      unit_q[unit_q.size() - 1].unit_last = 1'b1;
   endtask

   // receiver: checks words and drives stall bursts
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_word.out_last) begin
               units_seen++;
               if (rsp_word.format_error) err_units++;
            end
            if (out_word_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: unexpected word %h at %0t", rsp_word, $realtime);
            end else begin
               want = out_word_q.pop_front();
               if (rsp_word.out_byte !== want.out_byte || rsp_word.out_last !== want.out_last ||
                   rsp_word.is_discardable !== want.is_discardable ||
                   rsp_word.is_sync_frame !== want.is_sync_frame ||
                   rsp_word.format_error !== want.format_error) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("ERROR: mismatch at %0t: exp %h/%b%b%b%b got %h/%b%b%b%b",
                              $realtime, want.out_byte, want.out_last, want.is_discardable,
                              want.is_sync_frame, want.format_error, rsp_word.out_byte,
                              rsp_word.out_last, rsp_word.is_discardable,
                              rsp_word.is_sync_frame, rsp_word.format_error);
               end
            end
         end
         if (stall_left != 0) stall_left--;
         else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int sent;
      nal_phase  = ST_LENGTH;
      len_idx    = 0;
      nal_left   = '0;
      drop_acc   = 1'b1;
      sync_acc   = 1'b0;
      err_acc    = 1'b0;
      unit_fresh = 1'b1;
      swap_mode  = 1'b1;

      // IDR NAL of length 2, start code rewrite after reset
      stim_table.push_back(mk_row(8'h00, 0, 0, 1, {8'h00, 4'b0000}));
      stim_table.push_back(mk_row(8'h00, 0, 0, 1, {8'h00, 4'b0000}));
      stim_table.push_back(mk_row(8'h00, 0, 0, 1, {8'h00, 4'b0000}));
      stim_table.push_back(mk_row(8'h02, 0, 0, 1, {8'h01, 4'b0000}));
      stim_table.push_back(mk_row(8'h65, 0, 0, 1, {8'h65, 4'b0000}));
      stim_table.push_back(mk_row(8'hff, 1, 0, 1, {8'hff, 4'b1010}));
      // zero-length NAL, then a one-byte NAL with the forbidden bit, container sync
      stim_table.push_back(mk_row(8'h00, 0, 1, 0, '0));
      stim_table.push_back(mk_row(8'h00, 0, 0, 0, '0));
      stim_table.push_back(mk_row(8'h00, 0, 0, 0, '0));
      stim_table.push_back(mk_row(8'h00, 0, 0, 0, '0));
      stim_table.push_back(mk_row(8'h00, 0, 0, 0, '0));
      stim_table.push_back(mk_row(8'h00, 0, 0, 0, '0));
      stim_table.push_back(mk_row(8'h00, 0, 0, 0, '0));
      stim_table.push_back(mk_row(8'h01, 0, 0, 0, '0));
      stim_table.push_back(mk_row(8'h81, 1, 0, 1, {8'h81, 4'b1111}));
      // unit cut inside the length prefix
      stim_table.push_back(mk_row(8'h00, 0, 0, 0, '0));
      stim_table.push_back(mk_row(8'h00, 1, 0, 1, {8'h00, 4'b1101}));
      // unit cut inside the payload; late container sync is ignored
      stim_table.push_back(mk_row(8'h00, 0, 0, 0, '0));
      stim_table.push_back(mk_row(8'h00, 0, 0, 0, '0));
      stim_table.push_back(mk_row(8'h00, 0, 0, 0, '0));
      stim_table.push_back(mk_row(8'h05, 0, 0, 0, '0));
      stim_table.push_back(mk_row(8'h1f, 0, 1, 0, '0));
      stim_table.push_back(mk_row(8'h00, 1, 0, 0, '0));
      // single-byte unit
      stim_table.push_back(mk_row(8'hff, 1, 1, 1, {8'h00, 4'b1111}));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[k]) send_word(stim_table[k].word, stim_table[k].typed,
                                        stim_table[k].out);

      for (int p = 0; p < 4; p++) begin
         set_mode(p[0]);
         idle_on = (p != 3);
         sent = 0;
         while (sent < WORDS_PER_RUN) begin
            gen_unit();
            foreach (unit_q[k]) send_word(unit_q[k], 1'b0, '0);
            sent += unit_q.size();
         end
      end

      req_valid <= 1'b0;
      while (out_word_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d access units, both prefix modes, with gaps and stalls.",
               words_in, units_seen);
      $display("%0d units flagged a format error; %0d failures.", err_units, fail_count);
      if (fail_count == 0 && out_word_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
hdl/avclps_pkg.sv
hdl/avc_length_prefix_to_startcode_unit.sv
tb/tb_top.sv
